>>> rtl/mks_pkg.sv
// ----------------------------------------------------------------------------
// mks_pkg: shared types and constants of the matrix keypad scanner
// Holds the item kinds, register indexes, reset key maps and the structs
// that pass configuration and results between the modules.
// ----------------------------------------------------------------------------
package mks_pkg;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_EDGE = 2'd1,
		KIND_SCAN = 2'd2
	} kind_t;

	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_DELAY = 3'd0,
		REG_RELEASE_DELAY  = 3'd1,
		REG_ROW0_KEYS      = 3'd2,
		REG_ROW1_KEYS      = 3'd3,
		REG_ROW2_KEYS      = 3'd4,
		REG_ROW3_KEYS      = 3'd5
	} reg_idx_t;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned NUM_ROWS = 4;
	localparam int unsigned NUM_COLS = 4;
	localparam int unsigned ROW_W = $clog2(NUM_ROWS);
	localparam int unsigned COL_W = $clog2(NUM_COLS);
	localparam int unsigned CFG_DATA_W = NUM_COLS * CODE_W;

	localparam logic [DELAY_W-1:0] DEBOUNCE_RST = 16'd100;
	localparam logic [DELAY_W-1:0] RELEASE_RST  = 16'd100;

	// Column 0 character sits in the low byte: "123A", "456B", "789C", "*0#D".
	localparam logic [CFG_DATA_W-1:0] ROW0_KEYS_RST = 32'h4133_3231;
	localparam logic [CFG_DATA_W-1:0] ROW1_KEYS_RST = 32'h4236_3534;
	localparam logic [CFG_DATA_W-1:0] ROW2_KEYS_RST = 32'h4339_3837;
	localparam logic [CFG_DATA_W-1:0] ROW3_KEYS_RST = 32'h4423_302A;

	typedef logic [NUM_COLS-1:0][CODE_W-1:0] row_keys_t;

	typedef struct packed {
		logic [DELAY_W-1:0]       debounce_dly;
		logic [DELAY_W-1:0]       release_dly;
		row_keys_t [NUM_ROWS-1:0] keys;
	} cfg_t;

	typedef struct packed {
		logic              key_valid;
		logic [CODE_W-1:0] key_code;
		logic [ROW_W-1:0]  row_index;
		logic              row_active;
	} result_t;

endpackage

>>> rtl/mks_if.sv
// ----------------------------------------------------------------------------
// mks_if: handshake channels of the matrix keypad scanner
// Input items, result items and configuration writes, each with valid and
// ready; a beat moves when both are high at a rising clock edge.
// ----------------------------------------------------------------------------
interface mks_item_if;
	import mks_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [COL_W-1:0] column;

	modport source (output valid, output kind, output column, input ready);
	modport sink (input valid, input kind, input column, output ready);
endinterface

interface mks_result_if;
	import mks_pkg::*;

	logic              valid;
	logic              ready;
	logic              key_valid;
	logic [CODE_W-1:0] key_code;
	logic [ROW_W-1:0]  row_index;
	logic              row_active;

	modport source (output valid, output key_valid, output key_code, output row_index,
		output row_active, input ready);
	modport sink (input valid, input key_valid, input key_code, input row_index,
		input row_active, output ready);
endinterface

interface mks_cfg_if;
	import mks_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/matrix_keypad_scanner_top.sv
// A result is valid on the output in the cycle after its item is accepted.
// Throughput: one item per cycle; the only bound is the single result register,
// which refills in the same cycle its beat is taken.
// Configuration writes are registered when accepted; the config channel is always ready.
// Reset (arst_n low) clears the time counter, timestamps, pending column and row,
// and loads both delays with 100 and the key maps with the standard 4x4 layout.
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_top: 4x4 keypad scanner with debounce
// Takes tick, column edge and scan step items and reports debounced keys.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_top (
	input  logic         clk,
	input  logic         arst_n,
	mks_item_if.sink     item,
	mks_result_if.source result,
	mks_cfg_if.sink      cfg
);
	import mks_pkg::*;

	cfg_t    cfg_val;
	result_t res_d;
	logic    accept;
	logic    can_load;

	assign cfg.ready  = 1'b1;
	assign item.ready = can_load;
	assign accept     = item.valid && can_load;

	mks_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	mks_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (item.kind),
		.column (item.column),
		.cfg    (cfg_val),
		.res    (res_d)
	);

	mks_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res_d    (res_d),
		.can_load (can_load),
		.result   (result)
	);

endmodule

>>> rtl/mks_cfg_regs.sv
// ----------------------------------------------------------------------------
// mks_cfg_regs: configuration register file
// Holds the two delays and the four row key maps, written one beat at a time.
// ----------------------------------------------------------------------------
module mks_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [mks_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [mks_pkg::CFG_DATA_W-1:0] wr_data,
	output mks_pkg::cfg_t                  cfg
);
	import mks_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_dly <= DEBOUNCE_RST;
			cfg_q.release_dly  <= RELEASE_RST;
			cfg_q.keys[0]      <= ROW0_KEYS_RST;
			cfg_q.keys[1]      <= ROW1_KEYS_RST;
			cfg_q.keys[2]      <= ROW2_KEYS_RST;
			cfg_q.keys[3]      <= ROW3_KEYS_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_DEBOUNCE_DELAY: cfg_q.debounce_dly <= wr_data[DELAY_W-1:0];
				REG_RELEASE_DELAY:  cfg_q.release_dly  <= wr_data[DELAY_W-1:0];
				REG_ROW0_KEYS:      cfg_q.keys[0]      <= wr_data;
				REG_ROW1_KEYS:      cfg_q.keys[1]      <= wr_data;
				REG_ROW2_KEYS:      cfg_q.keys[2]      <= wr_data;
				REG_ROW3_KEYS:      cfg_q.keys[3]      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/mks_core.sv
// ----------------------------------------------------------------------------
// mks_core: scanner state and per-item update
// Keeps the millisecond counter, debounce and release timestamps, the
// pending column and the driven row, and forms the result of each item.
// ----------------------------------------------------------------------------
module mks_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [1:0]                kind,
	input  logic [mks_pkg::COL_W-1:0] column,
	input  mks_pkg::cfg_t             cfg,
	output mks_pkg::result_t          res
);
	import mks_pkg::*;

	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] last_edge_q;
	logic [TIME_W-1:0] last_report_q;
	logic              pend_valid_q;
	logic [COL_W-1:0]  pend_col_q;
	logic [ROW_W-1:0]  row_q;
	logic              started_q;

	logic [TIME_W-1:0] time_d;
	logic [TIME_W-1:0] last_edge_d;
	logic [TIME_W-1:0] last_report_d;
	logic              pend_valid_d;
	logic [COL_W-1:0]  pend_col_d;
	logic [ROW_W-1:0]  row_d;
	logic              started_d;

	logic [TIME_W-1:0] edge_gap;
	logic [TIME_W-1:0] report_gap;
	logic              edge_ok;
	logic              report_ok;
	logic [CODE_W-1:0] key_sel;

	// Both gaps are modulo 2^32, so the counter may wrap freely.
	assign edge_gap   = time_q - last_edge_q;
	assign report_gap = time_q - last_report_q;
	assign edge_ok    = edge_gap > {{(TIME_W-DELAY_W){1'b0}}, cfg.debounce_dly};
	assign report_ok  = report_gap > {{(TIME_W-DELAY_W){1'b0}}, cfg.release_dly};
	assign key_sel    = cfg.keys[row_q][pend_col_q];

	always_comb begin
		time_d        = time_q;
		last_edge_d   = last_edge_q;
		last_report_d = last_report_q;
		pend_valid_d  = pend_valid_q;
		pend_col_d    = pend_col_q;
		row_d         = row_q;
		started_d     = started_q;
		res.key_valid = 1'b0;
		res.key_code  = '0;
		case (kind_t'(kind))
			KIND_TICK: begin
				time_d = time_q + 32'd1;
			end
			KIND_EDGE: begin
				if (edge_ok) begin
					pend_valid_d = 1'b1;
					pend_col_d   = column;
					last_edge_d  = time_q;
				end
			end
			KIND_SCAN: begin
				// A pending column is consumed even when it comes too soon.
				pend_valid_d = 1'b0;
				if (pend_valid_q && report_ok) begin
					last_report_d = time_q;
					res.key_valid = 1'b1;
					res.key_code  = key_sel;
				end
				row_d     = row_q + 2'd1;
				started_d = 1'b1;
			end
			default: ;
		endcase
		res.row_index  = row_d;
		res.row_active = started_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q        <= '0;
			last_edge_q   <= '0;
			last_report_q <= '0;
			pend_valid_q  <= 1'b0;
			pend_col_q    <= '0;
			row_q         <= '0;
			started_q     <= 1'b0;
		end else if (accept) begin
			time_q        <= time_d;
			last_edge_q   <= last_edge_d;
			last_report_q <= last_report_d;
			pend_valid_q  <= pend_valid_d;
			pend_col_q    <= pend_col_d;
			row_q         <= row_d;
			started_q     <= started_d;
		end
	end

	a_scan_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_SCAN |=> !pend_valid_q)
		else $error("pending column survived a scan step");

	a_scan_advances_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_SCAN |=> row_q == $past(row_q) + 2'd1 && started_q)
		else $error("scan step did not advance the row");

	a_tick_advances_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_TICK |=> time_q == $past(time_q) + 32'd1)
		else $error("tick did not advance the time counter");

	a_report_time_only_on_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && kind == KIND_SCAN) |=> $stable(last_report_q))
		else $error("report time moved without a scan step");

	a_key_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.key_valid |-> pend_valid_q && kind == KIND_SCAN)
		else $error("key reported without a pending column");

endmodule

>>> rtl/mks_out_reg.sv
// ----------------------------------------------------------------------------
// mks_out_reg: result register
// Holds one result until the sink takes it; a new result may load in the
// same cycle the held one leaves.
// ----------------------------------------------------------------------------
module mks_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mks_pkg::result_t res_d,
	output logic             can_load,
	mks_result_if.source     result
);
	import mks_pkg::*;

	logic    valid_s1;
	result_t res_s1;

	assign can_load = !valid_s1 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (can_load) begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_s1 <= res_d;
		end
	end

	assign result.valid      = valid_s1;
	assign result.key_valid  = res_s1.key_valid;
	assign result.key_code   = res_s1.key_code;
	assign result.row_index  = res_s1.row_index;
	assign result.row_active = res_s1.row_active;

	a_held_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !result.ready |=> valid_s1 && $stable(res_s1))
		else $error("result register lost a stalled beat");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load && can_load |=> valid_s1)
		else $error("loaded result not marked valid");

	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !result.ready |-> !can_load)
		else $error("result register open while a beat is stalled");

endmodule
